/* design/pure_pursuit_step_top_defines.svh */
// assertion macros shared by the pursuit step rtl
// expects clk and rst_n in the scope of each use
`ifndef PURE_PURSUIT_STEP_TOP_DEFINES_SVH
`define PURE_PURSUIT_STEP_TOP_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pps_pkg.sv */
// shared types and constants for the pursuit step block
// no dependencies
package pps_pkg;

  localparam int SPEED_BITS = 10;
  localparam logic [SPEED_BITS-1:0] SPEED_RESET = 10'd10;
  localparam int OUT_POS_BITS = 12;
  localparam int SEP_BITS = 13;
  localparam logic [SEP_BITS-1:0] SEP_MAX = 13'h1fff;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_MAC,
    OP_SQRT,
    OP_DIV
  } pps_op_t;

  typedef struct packed {
    logic    start;
    pps_op_t op;
  } pps_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pps_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_CHECK,
    S_MULX,
    S_DIVX,
    S_MULY,
    S_DIVY,
    S_FIN
  } pps_state_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* design/pps_alu.sv */
// bit-serial arithmetic unit: shift-add multiply, digit square root, restoring divide
// depends on pps_pkg and pure_pursuit_step_top_defines.svh
`include "pure_pursuit_step_top_defines.svh"

module pps_alu #(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pps_pkg::pps_cmd_t    cmd,
  input  logic [COORD_BITS:0]  opa,
  input  logic [pps_pkg::imax(COORD_BITS+1, pps_pkg::SPEED_BITS)-1:0] opb,
  output pps_pkg::pps_sts_t    sts,
  output logic [COORD_BITS:0]  root,
  output logic [pps_pkg::SPEED_BITS-1:0] quo
);

  localparam int SB  = pps_pkg::SPEED_BITS;
  localparam int AB  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS + 2;
  localparam int PW  = AB + SB;
  localparam int WA  = pps_pkg::imax(SQW, PW);
  localparam int MB  = pps_pkg::imax(AB, SB);
  localparam int RW  = COORD_BITS + 4;
  localparam int CW  = $clog2(MB + 1);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_init;
  pps_pkg::pps_op_t op_r;
  logic [WA-1:0]    acc_r;
  logic [WA-1:0]    mc_r;
  logic [MB-1:0]    mp_r;
  logic [RW-1:0]    rem_r;
  logic [AB-1:0]    root_r;
  logic [SB-1:0]    quo_r;

  logic [WA-1:0]    acc_sum;
  logic [RW-1:0]    rem2;
  logic [RW-1:0]    trial;
  logic             sbit;
  logic [AB:0]      dtry;
  logic             dbit;

  assign acc_sum = acc_r + mc_r;
  assign rem2    = {rem_r[RW-3:0], acc_r[SQW-1 -: 2]};
  assign trial   = RW'({root_r, 2'b01});
  assign sbit    = (rem2 >= trial);
  assign dtry    = {rem_r[AB-1:0], quo_r[SB-1]};
  assign dbit    = (dtry >= {1'b0, root_r});

  always_comb begin
    unique case (cmd.op) inside
      pps_pkg::OP_MUL, pps_pkg::OP_MAC: cnt_init = CW'(MB);
      pps_pkg::OP_SQRT:                 cnt_init = CW'(AB);
      pps_pkg::OP_DIV:                  cnt_init = CW'(SB);
      default:                          cnt_init = CW'(MB);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= cnt_init;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= cmd.op;
      case (cmd.op) inside
        pps_pkg::OP_MUL, pps_pkg::OP_MAC: begin
          if (cmd.op == pps_pkg::OP_MUL) begin
            acc_r <= '0;
          end
          mc_r <= WA'(opa);
          mp_r <= opb;
        end
        pps_pkg::OP_SQRT: begin
          rem_r  <= '0;
          root_r <= '0;
        end
        pps_pkg::OP_DIV: begin
          // quotient fits the speed width, so the top bits form the first remainder
          rem_r <= RW'(acc_r[SB +: AB]);
          quo_r <= acc_r[SB-1:0];
        end
        default: begin
        end
      endcase
    end else if (busy_r) begin
      case (op_r) inside
        pps_pkg::OP_MUL, pps_pkg::OP_MAC: begin
          if (mp_r[0]) begin
            acc_r <= acc_sum;
          end
          mc_r <= mc_r << 1;
          mp_r <= mp_r >> 1;
        end
        pps_pkg::OP_SQRT: begin
          acc_r <= acc_r << 2;
          if (sbit) begin
            rem_r <= rem2 - trial;
          end else begin
            rem_r <= rem2;
          end
          root_r <= {root_r[AB-2:0], sbit};
        end
        pps_pkg::OP_DIV: begin
          if (dbit) begin
            rem_r <= RW'(dtry - {1'b0, root_r});
          end else begin
            rem_r <= RW'(dtry);
          end
          quo_r <= {quo_r[SB-2:0], dbit};
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && (cnt_r == CW'(1));
  assign root     = root_r;
  assign quo      = quo_r;

  `PPS_ASSERT_IMP(a_start_when_idle, cmd.start, !busy_r, "alu started while busy")
  `PPS_ASSERT_IMP(a_div_nonzero, cmd.start && cmd.op == pps_pkg::OP_DIV, root_r != '0, "divide by zero")
  `PPS_ASSERT_NXT(a_done_ends, sts.done && !cmd.start, !busy_r, "alu still busy after done")

endmodule

/* design/pure_pursuit_step_top.sv */
// Pursuit step: each target word moves a pursuer (reset at the origin) toward the target by
// speed*d/separation per axis, with a sticky capture when separation <= speed. One shared
// bit-serial unit does both squares, the square root, both speed products and both
// divisions, one bit per cycle, so one word is in flight at a time. A result waits in the
// output register so the next word can start. The speed register may be written only while
// idle.
// depends on pps_pkg, pps_alu and pure_pursuit_step_top_defines.svh
`include "pure_pursuit_step_top_defines.svh"

module pure_pursuit_step_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [COORD_BITS-1:0]            in_target_x,
  input  logic signed [COORD_BITS-1:0]            in_target_y,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [pps_pkg::OUT_POS_BITS-1:0] out_pursuer_x_now,
  output logic signed [pps_pkg::OUT_POS_BITS-1:0] out_pursuer_y_now,
  output logic [pps_pkg::SEP_BITS-1:0]            out_separation,
  output logic                                    out_captured,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pps_pkg::SPEED_BITS-1:0]          cfg_data
);

  localparam int SB  = pps_pkg::SPEED_BITS;
  localparam int AB  = COORD_BITS + 1;
  localparam int MB  = pps_pkg::imax(AB, SB);
  localparam int SW  = pps_pkg::imax(COORD_BITS, SB + 1) + 1;
  localparam int RXW = pps_pkg::imax(AB, pps_pkg::SEP_BITS);
  localparam int XW  = pps_pkg::imax(COORD_BITS, pps_pkg::OUT_POS_BITS);
  localparam int OPB = pps_pkg::OUT_POS_BITS;
  localparam logic signed [SW-1:0] CMAX = SW'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  pps_pkg::pps_state_t state_r, state_nxt;
  logic                first_r;
  logic [SB-1:0]       speed_r;
  logic [COORD_BITS-1:0] px_r, py_r, nx_r;
  logic                cap_r, mv_r;
  logic [AB-1:0]       ax_r, ay_r;
  logic                sx_r, sy_r;
  logic                out_valid_r;
  logic [OPB-1:0]      out_x_r, out_y_r;
  logic [pps_pkg::SEP_BITS-1:0] out_sep_r;
  logic                out_cap_r;

  pps_pkg::pps_cmd_t   cmd;
  pps_pkg::pps_sts_t   sts;
  logic [AB-1:0]       opa;
  logic [MB-1:0]       opb;
  logic [AB-1:0]       root;
  logic [SB-1:0]       quo;

  logic                accept, hit, fin_go;
  logic [AB-1:0]       dx_w, dy_w;
  logic signed [XW-1:0] px_x, py_x;
  logic [RXW-1:0]      root_x;
  logic [pps_pkg::SEP_BITS-1:0] sep_w;

  function automatic logic [COORD_BITS-1:0] move_coord(
    input logic [COORD_BITS-1:0] p,
    input logic                  neg,
    input logic [SB-1:0]         q
  );
    logic signed [SW-1:0] pe;
    logic signed [SW-1:0] st;
    logic signed [SW-1:0] sum;
    pe  = SW'($signed(p));
    st  = SW'($signed({1'b0, q}));
    if (neg) begin
      st = -st;
    end
    sum = pe + st;
    if (sum > CMAX) begin
      return CMAX[COORD_BITS-1:0];
    end else if (sum < CMIN) begin
      return CMIN[COORD_BITS-1:0];
    end
    return sum[COORD_BITS-1:0];
  endfunction

  pps_alu #(
    .COORD_BITS(COORD_BITS)
  ) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .opa  (opa),
    .opb  (opb),
    .sts  (sts),
    .root (root),
    .quo  (quo)
  );

  assign accept = in_valid && !in_stall;
  assign dx_w   = AB'(in_target_x) - AB'($signed(px_r));
  assign dy_w   = AB'(in_target_y) - AB'($signed(py_r));
  assign hit    = cap_r || (MB'(root) <= MB'(speed_r));
  assign fin_go = (state_r == pps_pkg::S_FIN) && (!out_valid_r || !out_stall);
  assign px_x   = XW'($signed(px_r));
  assign py_x   = XW'($signed(py_r));
  assign root_x = RXW'(root);
  assign sep_w  = (root_x > RXW'(pps_pkg::SEP_MAX)) ? pps_pkg::SEP_MAX
                                                     : root_x[pps_pkg::SEP_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pps_pkg::S_IDLE:  if (in_valid) state_nxt = pps_pkg::S_SQX;
      pps_pkg::S_SQX:   if (sts.done) state_nxt = pps_pkg::S_SQY;
      pps_pkg::S_SQY:   if (sts.done) state_nxt = pps_pkg::S_ROOT;
      pps_pkg::S_ROOT:  if (sts.done) state_nxt = pps_pkg::S_CHECK;
      pps_pkg::S_CHECK: state_nxt = hit ? pps_pkg::S_FIN : pps_pkg::S_MULX;
      pps_pkg::S_MULX:  if (sts.done) state_nxt = pps_pkg::S_DIVX;
      pps_pkg::S_DIVX:  if (sts.done) state_nxt = pps_pkg::S_MULY;
      pps_pkg::S_MULY:  if (sts.done) state_nxt = pps_pkg::S_DIVY;
      pps_pkg::S_DIVY:  if (sts.done) state_nxt = pps_pkg::S_FIN;
      pps_pkg::S_FIN:   if (fin_go) state_nxt = pps_pkg::S_IDLE;
      default:          state_nxt = pps_pkg::S_IDLE;
    endcase
  end

  // unit commands and operands
  always_comb begin
    in_stall  = (state_r != pps_pkg::S_IDLE);
    cmd.start = 1'b0;
    cmd.op    = pps_pkg::OP_MUL;
    opa       = ax_r;
    opb       = MB'(ax_r);
    unique case (state_r)
      pps_pkg::S_SQX: begin
        cmd.start = first_r;
        cmd.op    = pps_pkg::OP_MUL;
      end
      pps_pkg::S_SQY: begin
        cmd.start = first_r;
        cmd.op    = pps_pkg::OP_MAC;
        opa       = ay_r;
        opb       = MB'(ay_r);
      end
      pps_pkg::S_ROOT: begin
        cmd.start = first_r;
        cmd.op    = pps_pkg::OP_SQRT;
      end
      pps_pkg::S_MULX: begin
        cmd.start = first_r;
        cmd.op    = pps_pkg::OP_MUL;
        opb       = MB'(speed_r);
      end
      pps_pkg::S_MULY: begin
        cmd.start = first_r;
        cmd.op    = pps_pkg::OP_MUL;
        opa       = ay_r;
        opb       = MB'(speed_r);
      end
      pps_pkg::S_DIVX, pps_pkg::S_DIVY: begin
        cmd.start = first_r;
        cmd.op    = pps_pkg::OP_DIV;
      end
      pps_pkg::S_IDLE, pps_pkg::S_CHECK, pps_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pps_pkg::S_IDLE;
      first_r     <= 1'b0;
      speed_r     <= pps_pkg::SPEED_RESET;
      px_r        <= '0;
      py_r        <= '0;
      cap_r       <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= (state_nxt != state_r);
      out_valid_r <= fin_go || (out_valid_r && out_stall);
      if (cfg_valid) begin
        speed_r <= cfg_data;
      end
      if (state_r == pps_pkg::S_CHECK) begin
        cap_r <= hit;
        mv_r  <= !hit;
      end
      if (fin_go && mv_r) begin
        px_r <= nx_r;
        py_r <= move_coord(py_r, sy_r, quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r <= dx_w[AB-1] ? AB'(-dx_w) : dx_w;
      ay_r <= dy_w[AB-1] ? AB'(-dy_w) : dy_w;
      sx_r <= dx_w[AB-1];
      sy_r <= dy_w[AB-1];
    end
    // x quotient is still held while the y product is formed
    if (state_r == pps_pkg::S_MULY && first_r) begin
      nx_r <= move_coord(px_r, sx_r, quo);
    end
    if (fin_go) begin
      out_x_r   <= px_x[OPB-1:0];
      out_y_r   <= py_x[OPB-1:0];
      out_sep_r <= sep_w;
      out_cap_r <= cap_r;
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_pursuer_x_now = out_x_r;
  assign out_pursuer_y_now = out_y_r;
  assign out_separation    = out_sep_r;
  assign out_captured      = out_cap_r;

  `PPS_ASSERT_NXT(a_cap_sticky, cap_r, cap_r, "capture flag dropped")
  `PPS_ASSERT_NXT(a_pos_frozen, cap_r, $stable(px_r) && $stable(py_r), "pursuer moved after capture")
  `PPS_ASSERT_NXT(a_accept_starts, accept, state_r == pps_pkg::S_SQX && first_r, "word not started")

endmodule
